FILE: rtl/positional_list_buffer_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_BUFFER_UNIT_MACROS_SVH
`define POSITIONAL_LIST_BUFFER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PLB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants of the positional list buffer: field widths,
// operation and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item
    logic ptr_init;  // set the shift pointer for insert or remove
    logic rd;        // read one entry into the read register
    logic wr_shift;  // write the read register back one place over
    logic wr_val;    // write the item value
    logic commit;    // update the count and load the result
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic err;         // range or full error on the held item
    logic shift_more;  // another entry still has to move
  } stat_t;

endpackage

FILE: rtl/positional_list_buffer_unit.sv
// Sequencing: append, set, get, spare opcodes and errors pass through decode
// and done; insert and remove also pass one shift check and write per entry moved.
// Throughput: one item at a time; the memory has one write port, and each
// shift moves one entry per read/write pair; a new item is taken the cycle
// after the last commits.
// Reset: asynchronous, active low; clears the element count and handshake
// state, the entry memory and the result registers are not cleared.
// ----------------------------------------------------------------------------
// positional_list_buffer_unit
// Ordered list of signed words with append, insert, remove, get and set,
// kept in a single-port-write memory and shifted one entry per step.
// ----------------------------------------------------------------------------
module positional_list_buffer_unit import plb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [ST_W-1:0]         status_o,
  output logic [CNT_W-1:0]        count_o
);

  ctrl_t ctrl;
  stat_t stat;

  plb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  plb_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

endmodule

FILE: rtl/plb_dpath.sv
// ----------------------------------------------------------------------------
// plb_dpath
// Datapath: item registers, entry memory, shift pointer, element count and
// the result register.
// ----------------------------------------------------------------------------
module plb_dpath import plb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [ST_W-1:0]         status_o,
  output logic [CNT_W-1:0]        count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int HW = $clog2(DEPTH + 1);
  localparam int CW = (HW > POS_W) ? HW : POS_W;

  op_e                    op_q;
  logic [POS_W-1:0]       pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [HW-1:0]          held_q, held_d;
  logic [AW-1:0]          ptr_q;
  logic [VAL_W-1:0]       rd_q;
  logic [VAL_W-1:0]       mem [DEPTH];
  logic signed [VAL_W-1:0] rv_q;
  status_e                st_q;
  logic [CNT_W-1:0]       cnt_q;

  logic [CW-1:0] pos_w, held_w, ptr_w, depth_w;
  logic          full, range_err, full_err, shift_more;
  logic [AW-1:0] rd_addr, wr_addr;
  status_e       st_d;
  logic [CW-1:0] held_nx_w;

  // Widen the compare operands to one width
  assign pos_w   = CW'(pos_q);
  assign held_w  = CW'(held_q);
  assign ptr_w   = CW'(ptr_q);
  assign depth_w = CW'(DEPTH);
  assign full    = (held_w >= depth_w);

  // Check position and capacity for the held item
  always_comb begin
    range_err  = 1'b0;
    full_err   = 1'b0;
    shift_more = 1'b0;
    rd_addr    = pos_w[AW-1:0];
    wr_addr    = pos_w[AW-1:0];
    case (op_q)
      OP_APPEND: begin
        full_err = full;
        wr_addr  = held_w[AW-1:0];
      end
      OP_INSERT: begin
        range_err  = (pos_w > held_w);
        full_err   = !range_err && full;
        shift_more = (ptr_w > pos_w);
        rd_addr    = ptr_q - AW'(1);
      end
      OP_REMOVE: begin
        range_err  = (pos_w >= held_w);
        shift_more = ((ptr_w + CW'(1)) < held_w);
        rd_addr    = ptr_q + AW'(1);
      end
      OP_GET, OP_SET: begin
        range_err = (pos_w >= held_w);
      end
      default: begin
      end
    endcase
  end

  assign stat_o.op         = op_q;
  assign stat_o.err        = range_err || full_err;
  assign stat_o.shift_more = shift_more;

  // Form the status and the next count
  always_comb begin
    if (range_err) begin
      st_d = ST_RANGE;
    end else if (full_err) begin
      st_d = ST_FULL;
    end else begin
      st_d = ST_OK;
    end
    held_nx_w = held_w;
    if (st_d == ST_OK) begin
      if (op_q == OP_APPEND || op_q == OP_INSERT) begin
        held_nx_w = held_w + CW'(1);
      end else if (op_q == OP_REMOVE) begin
        held_nx_w = held_w - CW'(1);
      end
    end
    held_d = held_nx_w[HW-1:0];
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_e'(opcode_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // Hold the element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctrl_i.commit) begin
      held_q <= held_d;
    end
  end

  // Move the shift pointer one entry per step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ptr_init) begin
      ptr_q <= (op_q == OP_INSERT) ? held_w[AW-1:0] : pos_w[AW-1:0];
    end else if (ctrl_i.wr_shift) begin
      ptr_q <= (op_q == OP_INSERT) ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_shift) begin
      mem[ptr_q] <= rd_q;
    end else if (ctrl_i.wr_val) begin
      mem[wr_addr] <= val_q;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      st_q  <= st_d;
      cnt_q <= held_nx_w[CNT_W-1:0];
      if (op_q == OP_GET) begin
        rv_q <= range_err ? '1 : rd_q;
      end else begin
        rv_q <= '0;
      end
    end
  end

  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign count_o      = cnt_q;

endmodule

FILE: rtl/plb_ctrl.sv
// ----------------------------------------------------------------------------
// plb_ctrl
// Controller: sequences each item through decode, entry shifting and result
// delivery, and owns both handshakes.
// ----------------------------------------------------------------------------
module plb_ctrl import plb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        if (!stat_i.err) begin
          case (stat_i.op)
            OP_APPEND, OP_SET: ctrl_o.wr_val = 1'b1;
            OP_INSERT, OP_REMOVE: begin
              ctrl_o.ptr_init = 1'b1;
              state_d         = S_SHIFT_CHK;
            end
            OP_GET: ctrl_o.rd = 1'b1;
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_CHK: begin
        if (stat_i.shift_more) begin
          ctrl_o.rd = 1'b1;
          state_d   = S_SHIFT_WR;
        end else begin
          ctrl_o.wr_val = (stat_i.op == OP_INSERT);
          state_d       = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        ctrl_o.wr_shift = 1'b1;
        state_d         = S_SHIFT_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Raise valid on commit, drop it once the item is taken
  always_comb begin
    if (ctrl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_stall_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/plb_checker.sv
// ----------------------------------------------------------------------------
// plb_checker
// Port-level checks of the positional list buffer: result hold, status
// codes, one item in flight, and count behavior across results.
// ----------------------------------------------------------------------------
`include "positional_list_buffer_unit_macros.svh"

module plb_checker import plb_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VAL_W-1:0] read_value_o,
  input logic [ST_W-1:0]         status_o,
  input logic [CNT_W-1:0]        count_o
);

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] prev_cnt_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // Track the count of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
    end else if (out_fire) begin
      prev_cnt_q <= count_o;
    end
  end

  `PLB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_value_o) && $stable(status_o) && $stable(count_o), "stalled result changed")
  `PLB_ASSERT_SAME(a_status_code, clk_i, rst_ni, out_valid_o, status_o == ST_OK || status_o == ST_RANGE || status_o == ST_FULL, "unknown status code")
  `PLB_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_fire, in_stall_o, "second item taken while busy")
  `PLB_ASSERT_SAME(a_err_keeps_count, clk_i, rst_ni, out_fire && status_o != ST_OK, count_o == prev_cnt_q, "error result changed the count")

endmodule

bind positional_list_buffer_unit plb_checker u_plb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .count_o      (count_o)
);
